// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  // Default sizes of the queue
  localparam int unsigned DepthDefault    = 16;
  localparam int unsigned KeyBitsDefault  = 16;
  localparam int unsigned DataBitsDefault = 16;

  // Fixed widths of the result fields
  localparam int unsigned OutBits   = 16;
  localparam int unsigned CountBits = 5;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } spq_op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } spq_status_e;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_HOLD    = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_EXTRACT = 2'd2
  } spq_cmd_e;

  typedef struct packed {
    spq_cmd_e cmd;
    logic     descending;
  } spq_ctrl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sorted row. Keep, take the new item, take the left
// neighbor (insert) or take the right neighbor (extract).
module spq_cell #(
  parameter int unsigned KeyBits  = spq_pkg::KeyBitsDefault,
  parameter int unsigned DataBits = spq_pkg::DataBitsDefault
) (
  input  logic                clk_i,
  input  spq_pkg::spq_ctrl_t  ctrl_i,
  input  logic [KeyBits-1:0]  new_key_i,
  input  logic [DataBits-1:0] new_data_i,
  input  logic                valid_i,
  input  logic                ahead_i,
  input  logic                shift_in_i,
  input  logic [KeyBits-1:0]  left_key_i,
  input  logic [DataBits-1:0] left_data_i,
  input  logic [KeyBits-1:0]  right_key_i,
  input  logic [DataBits-1:0] right_data_i,
  output logic                better_o,
  output logic [KeyBits-1:0]  key_o,
  output logic [DataBits-1:0] data_o,
  output logic [KeyBits-1:0]  key_next_o,
  output logic [DataBits-1:0] data_next_o
);

  logic [KeyBits-1:0]  key_q, key_d;
  logic [DataBits-1:0] data_q, data_d;

  // Stored entry beats the incoming key strictly, and so does every slot
  // to its left; the first slot that gives way stops the scan
  always_comb begin
    if (ctrl_i.descending) begin
      better_o = valid_i && ahead_i && (key_q > new_key_i);
    end else begin
      better_o = valid_i && ahead_i && (key_q < new_key_i);
    end
  end

  always_comb begin
    key_d  = key_q;
    data_d = data_q;
    unique case (ctrl_i.cmd)
      spq_pkg::CMD_INSERT: begin
        if (!better_o) begin
          if (shift_in_i) begin
            key_d  = left_key_i;
            data_d = left_data_i;
          end else begin
            key_d  = new_key_i;
            data_d = new_data_i;
          end
        end
      end
      spq_pkg::CMD_EXTRACT: begin
        key_d  = right_key_i;
        data_d = right_data_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign key_o       = key_q;
  assign data_o      = data_q;
  assign key_next_o  = key_d;
  assign data_next_o = data_d;

endmodule

// ----- hw/rtl/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// The result of an input transfer is registered in the output register in the cycle after it.
// One insert or extract per cycle unless results back up; the row of cells
//   updates every slot at once and the output register lets the next item in.
// Reset (rst_ni low, asynchronous): queue empty, ascending order, no result.
//   Slot contents are left unreset; only slots below the count are ever read.

module sorted_priority_queue_unit #(
  parameter int unsigned Depth    = spq_pkg::DepthDefault,
  parameter int unsigned KeyBits  = spq_pkg::KeyBitsDefault,
  parameter int unsigned DataBits = spq_pkg::DataBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_data_i,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [KeyBits-1:0]                item_key_i,
  input  logic [DataBits-1:0]               item_data_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [spq_pkg::OutBits-1:0]       out_key_o,
  output logic [spq_pkg::OutBits-1:0]       out_data_o,
  output logic [spq_pkg::CountBits-1:0]     count_o,
  output logic                              best_valid_o,
  output logic [spq_pkg::OutBits-1:0]       best_key_o,
  output logic [spq_pkg::OutBits-1:0]       best_data_o
);

  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned KeyW  = (KeyBits > spq_pkg::OutBits) ? KeyBits : spq_pkg::OutBits;
  localparam int unsigned DataW = (DataBits > spq_pkg::OutBits) ? DataBits : spq_pkg::OutBits;
  localparam int unsigned CntXW = (CntW > spq_pkg::CountBits) ? CntW : spq_pkg::CountBits;

  // Ordering register, written through its own channel, always ready
  logic descending_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else if (cfg_valid_i) begin
      descending_q <= cfg_data_i;
    end
  end

  // Input transfer: take a new item whenever the output slot is free or drains
  logic in_xfer;
  logic full, empty;
  logic [CntW-1:0] count_q, count_d;
  spq_pkg::spq_status_e status_d;
  spq_pkg::spq_ctrl_t   ctrl;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(Depth));
  assign empty      = (count_q == '0);

  // Decode the operation into a row command; drop full inserts and empty extracts
  always_comb begin
    ctrl.descending = descending_q;
    ctrl.cmd        = spq_pkg::CMD_HOLD;
    count_d         = count_q;
    status_d        = spq_pkg::STATUS_OK;
    if (in_xfer) begin
      unique case (spq_pkg::spq_op_e'(operation_i))
        spq_pkg::OP_INSERT: begin
          if (full) begin
            status_d = spq_pkg::STATUS_FULL;
          end else begin
            ctrl.cmd = spq_pkg::CMD_INSERT;
            count_d  = count_q + CntW'(1);
          end
        end
        spq_pkg::OP_EXTRACT: begin
          if (empty) begin
            status_d = spq_pkg::STATUS_EMPTY;
          end else begin
            ctrl.cmd = spq_pkg::CMD_EXTRACT;
            count_d  = count_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Row of cells: slot 0 is the head. Each cell sees its left and right
  // neighbor; an insert shifts the tail right, an extract shifts all left.
  // A cell stays ahead of the new item only if every cell to its left does
  // too, so the insert lands at the first slot that gives way even when the
  // order was flipped while entries were held.
  logic [Depth-1:0]               better;
  logic [Depth-1:0][KeyBits-1:0]  cell_key;
  logic [Depth-1:0][DataBits-1:0] cell_data;
  logic [Depth-1:0][KeyBits-1:0]  cell_key_next;
  logic [Depth-1:0][DataBits-1:0] cell_data_next;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                ahead;
    logic                shift_in;
    logic [KeyBits-1:0]  left_key, right_key;
    logic [DataBits-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      // Head has no left neighbor: it takes the new item when it loses
      assign ahead     = 1'b1;
      assign shift_in  = 1'b0;
      assign left_key  = '0;
      assign left_data = '0;
    end else begin : g_body
      // Shift from the left when the left cell also gives way
      assign ahead     = better[i-1];
      assign shift_in  = !better[i-1];
      assign left_key  = cell_key[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_key  = '0;
      assign right_data = '0;
    end else begin : g_inner
      assign right_key  = cell_key[i+1];
      assign right_data = cell_data[i+1];
    end

    spq_cell #(
      .KeyBits (KeyBits),
      .DataBits(DataBits)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_key_i   (item_key_i),
      .new_data_i  (item_data_i),
      .valid_i     (count_q > CntW'(i)),
      .ahead_i     (ahead),
      .shift_in_i  (shift_in),
      .left_key_i  (left_key),
      .left_data_i (left_data),
      .right_key_i (right_key),
      .right_data_i(right_data),
      .better_o    (better[i]),
      .key_o       (cell_key[i]),
      .data_o      (cell_data[i]),
      .key_next_o  (cell_key_next[i]),
      .data_next_o (cell_data_next[i])
    );
  end

  // Result fields, fitted to the fixed output widths
  logic [KeyW-1:0]  head_key_x, best_key_x;
  logic [DataW-1:0] head_data_x, best_data_x;
  logic [CntXW-1:0] count_x;
  logic             extracted, best_valid_d;

  assign extracted    = (ctrl.cmd == spq_pkg::CMD_EXTRACT);
  assign best_valid_d = (count_d != '0);
  assign head_key_x   = KeyW'(cell_key[0]);
  assign head_data_x  = DataW'(cell_data[0]);
  assign best_key_x   = KeyW'(cell_key_next[0]);
  assign best_data_x  = DataW'(cell_data_next[0]);
  assign count_x      = CntXW'(count_d);

  // Output register: hold until the result transfer, load on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_xfer) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_o     <= status_d;
      out_key_o    <= extracted ? head_key_x[spq_pkg::OutBits-1:0] : '0;
      out_data_o   <= extracted ? head_data_x[spq_pkg::OutBits-1:0] : '0;
      count_o      <= count_x[spq_pkg::CountBits-1:0];
      best_valid_o <= best_valid_d;
      best_key_o   <= best_valid_d ? best_key_x[spq_pkg::OutBits-1:0] : '0;
      best_data_o  <= best_valid_d ? best_data_x[spq_pkg::OutBits-1:0] : '0;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int unsigned DEPTH       = DepthDefault;
  localparam int unsigned KEY_W       = KeyBitsDefault;
  localparam int unsigned TAG_W       = DataBitsDefault;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 5;
  // Idle cycles before an order write or a drain once every result is back
  localparam int unsigned SETTLE_CYCLES = 2;
  // Jobs at the end of the run that go with no idling on either side
  localparam int unsigned CALM_TAIL   = 200;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 119;
  localparam int unsigned MAX_REPORTS = 10;
  // Watchdog limit, set well above the worst-case run time
  localparam longint unsigned WATCHDOG_NS = 6_000_000;

  typedef enum logic [1:0] {
    JOB_OP,
    JOB_ORDER,
    JOB_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e  kind;
    spq_op_e    op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic       descending;
  } job_t;

  typedef struct packed {
    spq_status_e            status;
    logic [OutBits-1:0]     taken_key;
    logic [OutBits-1:0]     taken_tag;
    logic [CountBits-1:0]   held;
    logic                   head_valid;
    logic [OutBits-1:0]     head_key;
    logic [OutBits-1:0]     head_tag;
  } queue_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i  = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 operation_i = 1'b0;
  logic [KEY_W-1:0]     item_key_i  = '0;
  logic [TAG_W-1:0]     item_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           status_o;
  logic [OutBits-1:0]   out_key_o;
  logic [OutBits-1:0]   out_data_o;
  logic [CountBits-1:0] count_o;
  logic                 best_valid_o;
  logic [OutBits-1:0]   best_key_o;
  logic [OutBits-1:0]   best_data_o;

  sorted_priority_queue_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .item_key_i   (item_key_i),
    .item_data_i  (item_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_key_o    (out_key_o),
    .out_data_o   (out_data_o),
    .count_o      (count_o),
    .best_valid_o (best_valid_o),
    .best_key_o   (best_key_o),
    .best_data_o  (best_data_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Jobs waiting for the driver, and results the queue still owes us
  job_t          pending_jobs[$];
  queue_result_t awaited[$];

  // Our own copy of the sorted list; slot 0 is the head
  logic [KEY_W-1:0] slot_key [DEPTH];
  logic [TAG_W-1:0] slot_tag [DEPTH];
  int unsigned      held_count = 0;
  logic             order_desc = 1'b0;

  // Handshake flags sampled at the rising edge, consumed at the falling edge
  logic in_took  = 1'b0;
  logic cfg_took = 1'b0;
  logic calm     = 1'b0;

  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  int unsigned settle     = 0;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned inserts_seen = 0;
  int unsigned extracts_seen = 0;
  int unsigned full_drops   = 0;
  int unsigned empty_pulls  = 0;
  int unsigned order_writes = 0;

  // A stored key stays ahead of a new one only if it is strictly better
  function automatic logic stays_ahead(logic [KEY_W-1:0] stored, logic [KEY_W-1:0] incoming);
    return order_desc ? (stored > incoming) : (stored < incoming);
  endfunction

  // Apply one transfer to the shadow list and return the result it owes
  function automatic queue_result_t queue_apply(spq_op_e op, logic [KEY_W-1:0] key,
                                                logic [TAG_W-1:0] tag);
    queue_result_t r;
    int unsigned   pos;
    int unsigned   i;
    r = '0;
    r.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && stays_ahead(slot_key[pos], key)) pos++;
        // Shift the tail down one slot to open the gap
        for (i = held_count; i > pos; i--) begin
          slot_key[i] = slot_key[i-1];
          slot_tag[i] = slot_tag[i-1];
        end
        slot_key[pos] = key;
        slot_tag[pos] = tag;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.taken_key = OutBits'(slot_key[0]);
        r.taken_tag = OutBits'(slot_tag[0]);
        for (i = 1; i < held_count; i++) begin
          slot_key[i-1] = slot_key[i];
          slot_tag[i-1] = slot_tag[i];
        end
        held_count--;
      end
    end
    r.held = CountBits'(held_count);
    if (held_count > 0) begin
      r.head_valid = 1'b1;
      r.head_key   = OutBits'(slot_key[0]);
      r.head_tag   = OutBits'(slot_tag[0]);
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] result %0d: %s expected %0h, got %0h", $realtime, results_seen, what,
               want, got);
  endtask

  task automatic compare_result(queue_result_t want, queue_result_t got);
    if (got.status !== want.status)         note_mismatch("status", want.status, got.status);
    if (got.taken_key !== want.taken_key)   note_mismatch("out_key", want.taken_key, got.taken_key);
    if (got.taken_tag !== want.taken_tag)   note_mismatch("out_data", want.taken_tag, got.taken_tag);
    if (got.held !== want.held)             note_mismatch("count", want.held, got.held);
    if (got.head_valid !== want.head_valid) note_mismatch("best_valid", want.head_valid,
                                                          got.head_valid);
    if (got.head_key !== want.head_key)     note_mismatch("best_key", want.head_key, got.head_key);
    if (got.head_tag !== want.head_tag)     note_mismatch("best_data", want.head_tag, got.head_tag);
  endtask

  task automatic add_op(spq_op_e op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    job_t j;
    j.kind = JOB_OP;
    j.op = op;
    j.key = key;
    j.tag = tag;
    j.descending = 1'b0;
    pending_jobs.push_back(j);
  endtask

  task automatic add_order(logic descending);
    job_t j;
    j.kind = JOB_ORDER;
    j.op = OP_INSERT;
    j.key = '0;
    j.tag = '0;
    j.descending = descending;
    pending_jobs.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.op = OP_INSERT;
    j.key = '0;
    j.tag = '0;
    j.descending = 1'b0;
    pending_jobs.push_back(j);
  endtask

  // Favor keys that pile up into ties, near both ends of the range
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0:       k = KEY_W'($urandom_range(0, 7));
      1:       k = {KEY_W{1'b1}} ^ KEY_W'($urandom_range(0, 7));
      2:       k = $urandom_range(0, 1) ? {KEY_W{1'b1}} : '0;
      default: k = KEY_W'($urandom);
    endcase
    return k;
  endfunction

  // Sample every handshake at the rising edge; predict on input transfers
  // and check on result transfers. Check before predicting, since a result
  // never belongs to the input taken at the same edge.
  always @(posedge clk_i) begin : result_monitor
    queue_result_t got;
    queue_result_t want;
    if (!rst_ni) begin
      in_took  = 1'b0;
      cfg_took = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got.status     = spq_status_e'(status_o);
        got.taken_key  = out_key_o;
        got.taken_tag  = out_data_o;
        got.held       = count_o;
        got.head_valid = best_valid_o;
        got.head_key   = best_key_o;
        got.head_tag   = best_data_o;
        if (awaited.size() == 0) begin
          note_mismatch("unrequested result, count", 0, count_o);
        end else begin
          want = awaited.pop_front();
          compare_result(want, got);
        end
      end

      in_took = in_valid_i && in_ready_o;
      if (in_took) begin
        want = queue_apply(spq_op_e'(operation_i), item_key_i, item_data_i);
        awaited.push_back(want);
        if (operation_i == OP_INSERT) inserts_seen++;
        else extracts_seen++;
        if (want.status == STATUS_FULL)  full_drops++;
        if (want.status == STATUS_EMPTY) empty_pulls++;
      end

      cfg_took = cfg_valid_i && cfg_ready_o;
      if (cfg_took) begin
        // Held entries keep their order; only later inserts see the change
        order_desc = cfg_data_i;
        order_writes++;
      end
    end
  end

  // Drive both senders and the result ready at the falling edge. The valid and ready
  // ports get exactly one nonblocking update per edge, the data ports at most one.
  always @(negedge clk_i) begin : stim_driver
    logic in_v;
    logic cfg_v;
    job_t job;
    if (rst_ni) begin
      in_v  = in_valid_i && !in_took;
      cfg_v = cfg_valid_i && !cfg_took;
      calm  = pending_jobs.size() < CALM_TAIL;

      // Open an idle burst after some input transfers
      if (in_valid_i && in_took && !calm && $urandom_range(0, 4) == 0)
        send_gap = $urandom_range(1, 13);

      if (!in_v && !cfg_v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_jobs.size() > 0) begin
          job = pending_jobs[0];
          if (job.kind == JOB_OP) begin
            void'(pending_jobs.pop_front());
            in_v = 1'b1;
            operation_i <= job.op;
            item_key_i  <= job.key;
            item_data_i <= job.tag;
          end else if (awaited.size() != 0) begin
            // Hold until every owed result has come back
            settle = 0;
          end else if (settle < SETTLE_CYCLES) begin
            settle++;
          end else begin
            settle = 0;
            void'(pending_jobs.pop_front());
            if (job.kind == JOB_ORDER) begin
              cfg_v = 1'b1;
              cfg_data_i <= job.descending;
            end
          end
        end
      end
      in_valid_i  <= in_v;
      cfg_valid_i <= cfg_v;

      // Stall the result side in bursts, except in the calm tail
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : test_sequence
    int unsigned phase;
    int unsigned n;
    int unsigned insert_pct;

    // Directed: empty extract, extremes, equal keys, fill to full, overflow
    add_op(OP_EXTRACT, 16'hFFFF, 16'hFFFF);
    add_op(OP_INSERT, 16'h8000, 16'h0001);
    add_op(OP_INSERT, 16'h8000, 16'h0002);
    add_op(OP_INSERT, 16'hFFFF, 16'hFFFF);
    add_op(OP_INSERT, 16'h0000, 16'h0000);
    add_op(OP_INSERT, 16'h0000, 16'hFFFF);
    for (n = 1; n <= 11; n++) add_op(OP_INSERT, KEY_W'(n * 16'h1111), TAG_W'(~n));
    add_op(OP_INSERT, 16'h0001, 16'hAAAA);
    add_op(OP_EXTRACT, 16'h0000, 16'h0000);
    add_op(OP_EXTRACT, 16'h5555, 16'h5555);
    // Flip to largest-first while entries are still held
    add_order(1'b1);
    add_op(OP_INSERT, 16'h9000, 16'h5555);
    add_op(OP_INSERT, 16'hFFFF, 16'h1234);
    add_op(OP_EXTRACT, 16'h0000, 16'h0000);

    // Random phases: fill-heavy, drain-heavy or balanced under either order
    for (phase = 0; phase < PHASES; phase++) begin
      add_order(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && phase % 4 == 1) add_drain();
        add_op(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT,
               pick_key(), TAG_W'($urandom));
      end
    end

    // Hold reset, then release it away from the sampling edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all jobs to go out and every result to come back
    while (pending_jobs.size() != 0 || in_valid_i || cfg_valid_i || awaited.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts (%0d dropped full), %0d extracts (%0d empty).",
             results_seen, inserts_seen, full_drops, extracts_seen, empty_pulls);
    $display("Order register written %0d times; %0d mismatches.", order_writes, mismatches);
    if (mismatches == 0) begin
      $display("sorted_priority_queue_unit test passed");
    end else begin
      $display("sorted_priority_queue_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Timeout with %0d jobs and %0d results outstanding.", pending_jobs.size(),
             awaited.size());
    $display("sorted_priority_queue_unit test failed");
    $finish;
  end

endmodule
